FILE: src/hrhp_pkg.sv
// ---------------------------------------------------------------------------
// HTTP response head parser: shared package
// Codes, character constants, match tables and the item and state types.
// ---------------------------------------------------------------------------
package hrhp_pkg;

	localparam int COUNT_BITS = 32;

	localparam logic [2:0] REQ_CONNECT    = 3'd0;
	localparam logic [2:0] REQ_DATA       = 3'd1;
	localparam logic [2:0] REQ_DISCONNECT = 3'd2;
	localparam logic [2:0] REQ_TIMEOUT    = 3'd3;
	localparam logic [2:0] REQ_CONN_ERROR = 3'd4;

	localparam logic [1:0] PHASE_IDLE   = 2'd0;
	localparam logic [1:0] PHASE_STATUS = 2'd1;
	localparam logic [1:0] PHASE_HEADER = 2'd2;
	localparam logic [1:0] PHASE_BODY   = 2'd3;

	localparam logic ERR_TIMEOUT   = 1'b0;
	localparam logic ERR_CONN_FAIL = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_WILD  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [4:0] PREFIX_LEN = 5'd9;
	localparam logic [4:0] NAME_LEN   = 5'd14;
	localparam logic [4:0] POS_MAX    = 5'd31;
	localparam logic [9:0] CODE_MAX   = 10'd999;

	// "HTTP/*.* " with '*' as a wildcard
	localparam logic [7:0] STATUS_PREFIX [9] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h2A, 8'h2E, 8'h2A, 8'h20
	};

	// "content-length", lower case
	localparam logic [7:0] LENGTH_NAME [14] = '{
		8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
		8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
	};

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [9:0]  status_code;
		logic [31:0] content_length;
		logic        headers_done;
		logic        body_valid;
		logic [7:0]  body_byte;
		logic [31:0] body_count;
		logic        error_valid;
		logic        error_code;
	} res_item_t;

	typedef struct packed {
		logic [1:0]            phase;
		logic [4:0]            line_position;
		logic                  prefix_ok;
		logic                  name_matches;
		logic                  in_value;
		logic                  digits_ended;
		logic                  colon_seen;
		logic [9:0]            code_acc;
		logic [31:0]           length_acc;
		logic [COUNT_BITS-1:0] byte_total;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:         PHASE_IDLE,
		line_position: '0,
		prefix_ok:     1'b1,
		name_matches:  1'b1,
		in_value:      1'b0,
		digits_ended:  1'b0,
		colon_seen:    1'b0,
		code_acc:      '0,
		length_acc:    '0,
		byte_total:    '0
	};

endpackage

FILE: src/hrhp_if.sv
// ---------------------------------------------------------------------------
// HTTP response head parser: channel interfaces
// Valid/ready channels for request beats and result beats.
// ---------------------------------------------------------------------------
interface hrhp_req_if;
	import hrhp_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface hrhp_res_if;
	import hrhp_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: src/hrhp_step.sv
// ---------------------------------------------------------------------------
// HTTP response head parser: per-beat update
// Next parser state and result for one request beat.
// ---------------------------------------------------------------------------
module hrhp_step (
	input  hrhp_pkg::parse_state_t state,
	input  hrhp_pkg::req_item_t    item,
	output hrhp_pkg::parse_state_t state_next,
	output hrhp_pkg::res_item_t    result
);
	import hrhp_pkg::*;

	logic [7:0]  c;
	logic [7:0]  lc;
	logic        is_digit;
	logic [3:0]  digit;
	logic [13:0] code_ext;
	logic [13:0] code_v;
	logic [35:0] len_ext;
	logic [35:0] len_v;
	logic [9:0]  code_sat;
	logic [31:0] len_sat;
	logic [4:0]  pos_inc;

	always_comb begin
		c        = item.rx_byte;
		lc       = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
		is_digit = c >= CH_ZERO && c <= CH_NINE;
		digit    = 4'(c - CH_ZERO);
		code_ext = 14'(state.code_acc);
		code_v   = (code_ext << 3) + (code_ext << 1) + 14'(digit);
		code_sat = (code_v > 14'(CODE_MAX)) ? CODE_MAX : code_v[9:0];
		len_ext  = 36'(state.length_acc);
		len_v    = (len_ext << 3) + (len_ext << 1) + 36'(digit);
		len_sat  = (|len_v[35:32]) ? '1 : len_v[31:0];
		pos_inc  = (state.line_position < POS_MAX) ? state.line_position + 5'd1
			: state.line_position;
	end

	always_comb begin
		parse_state_t s;
		logic         hdr_done;
		logic         body_v;
		logic         err_v;
		logic         err_c;

		s        = state;
		hdr_done = 1'b0;
		body_v   = 1'b0;
		err_v    = 1'b0;
		err_c    = ERR_TIMEOUT;

		unique case (item.req_type)
			REQ_CONNECT: begin
				s       = STATE_RESET;
				s.phase = PHASE_STATUS;
			end
			REQ_DISCONNECT: begin
				s.phase = PHASE_IDLE;
			end
			REQ_TIMEOUT, REQ_CONN_ERROR: begin
				s.phase = PHASE_IDLE;
				err_v   = 1'b1;
				err_c   = (item.req_type == REQ_CONN_ERROR) ? ERR_CONN_FAIL : ERR_TIMEOUT;
			end
			REQ_DATA: begin
				unique case (state.phase)
					PHASE_STATUS: begin
						if (c == CH_LF) begin
							if (state.line_position < PREFIX_LEN)
								s.prefix_ok = 1'b0;
							s.phase         = PHASE_HEADER;
							s.line_position = '0;
							s.name_matches  = 1'b1;
							s.in_value      = 1'b0;
							s.digits_ended  = 1'b0;
							s.colon_seen    = 1'b0;
						end else if (c != CH_CR) begin
							if (state.line_position < PREFIX_LEN) begin
								if (STATUS_PREFIX[state.line_position[3:0]] != CH_WILD &&
									STATUS_PREFIX[state.line_position[3:0]] != c)
									s.prefix_ok = 1'b0;
							end else if (state.prefix_ok && !state.digits_ended) begin
								if (is_digit)
									s.code_acc = code_sat;
								else
									s.digits_ended = 1'b1;
							end
							s.line_position = pos_inc;
						end
					end
					PHASE_HEADER: begin
						if (c == CH_LF) begin
							if (state.line_position == '0) begin
								s.phase  = PHASE_BODY;
								hdr_done = 1'b1;
							end else if (!state.in_value && !state.colon_seen &&
								state.name_matches && state.line_position == NAME_LEN) begin
								// bare name line with no value
								s.length_acc = '0;
							end
							s.line_position = '0;
							s.name_matches  = 1'b1;
							s.in_value      = 1'b0;
							s.digits_ended  = 1'b0;
							s.colon_seen    = 1'b0;
						end else if (c != CH_CR) begin
							if (state.in_value) begin
								if (state.name_matches && !state.digits_ended) begin
									if (is_digit)
										s.length_acc = len_sat;
									else
										s.digits_ended = 1'b1;
								end
							end else if (state.colon_seen && c == CH_SPACE) begin
								// ": " splits name from value
								s.colon_seen   = 1'b0;
								s.name_matches = state.name_matches &&
									state.line_position == NAME_LEN + 5'd1;
								s.in_value     = 1'b1;
								s.digits_ended = 1'b0;
								if (s.name_matches)
									s.length_acc = '0;
							end else begin
								s.name_matches = state.name_matches && !state.colon_seen;
								s.colon_seen   = (c == CH_COLON);
								if (c != CH_COLON) begin
									if (state.line_position >= NAME_LEN ||
										lc != LENGTH_NAME[state.line_position[3:0]])
										s.name_matches = 1'b0;
								end else if (state.line_position >= NAME_LEN) begin
									s.name_matches = s.name_matches &&
										state.line_position == NAME_LEN;
								end
							end
							s.line_position = pos_inc;
						end
					end
					PHASE_BODY: begin
						body_v = 1'b1;
						if (!(&state.byte_total))
							s.byte_total = state.byte_total + COUNT_BITS'(1);
					end
					PHASE_IDLE: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		state_next            = s;
		result.phase          = s.phase;
		result.status_code    = s.prefix_ok ? s.code_acc : '0;
		result.content_length = s.length_acc;
		result.headers_done   = hdr_done;
		result.body_valid     = body_v;
		result.body_byte      = body_v ? c : '0;
		result.body_count     = 32'(s.byte_total);
		result.error_valid    = err_v;
		result.error_code     = err_c;
	end

endmodule

FILE: src/http_response_head_parser_unit.sv
// ---------------------------------------------------------------------------
// HTTP response head parser
// Status line, content-length and body pass-through, one beat per cycle unless stalled.
// ---------------------------------------------------------------------------
// Takes one request beat (connect, data byte, disconnect, timeout, error) per
// clock and returns exactly one result beat for each. The beat is registered
// in the input register, the parser state is updated from it in one step, and
// the result lands in an output register. While a result waits, one more
// request beat can still enter the input register; after that the request
// side stalls until the result is taken. The sustained rate is one beat per
// cycle while the result side is ready, bounded by the combinational update.
module http_response_head_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	hrhp_req_if.sink   request,
	hrhp_res_if.source result
);
	import hrhp_pkg::*;

	parse_state_t state_q;
	parse_state_t state_d;
	req_item_t    item_s1;
	logic         valid_s1;
	res_item_t    res_d;
	res_item_t    res_s2;
	logic         valid_s2;
	logic         advance;
	logic         take;

	assign advance       = !valid_s2 || result.ready;
	assign request.ready = !valid_s1 || advance;
	assign take          = request.valid && request.ready;
	assign result.valid  = valid_s2;
	assign result.item   = res_s2;

	hrhp_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_d),
		.result     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (request.ready)
				valid_s1 <= request.valid;
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1)
					state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= request.item;
		if (advance && valid_s1)
			res_s2 <= res_d;
	end

endmodule

FILE: src/hrhp_checker.sv
// ---------------------------------------------------------------------------
// HTTP response head parser: port checker
// Assertions on result beats seen at the top-level ports.
// ---------------------------------------------------------------------------
module hrhp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input hrhp_pkg::res_item_t res_item
);
	import hrhp_pkg::*;

	// body bytes only come out in the body phase
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.body_valid |-> res_item.phase == PHASE_BODY)
		else $error("body beat outside body phase");

	// end of headers moves to body and carries no body byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.headers_done |->
			res_item.phase == PHASE_BODY && !res_item.body_valid)
		else $error("headers_done with wrong phase or body byte");

	// an error event always drops the parser to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.error_valid |-> res_item.phase == PHASE_IDLE)
		else $error("error beat not idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.status_code <= CODE_MAX)
		else $error("status code above saturation");

	// hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("stalled result beat changed");

endmodule

bind http_response_head_parser_unit hrhp_checker u_hrhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_item  (result.item)
);

FILE: tb/tb_http_response_head_parser_unit.sv
// ---------------------------------------------------------------------------
// Testbench for http_response_head_parser_unit
// Sends connect, data, disconnect, timeout and error beats through the
// request channel: first a short directed table, then generated responses
// with good, broken and saturating status lines, content-length headers and
// bodies. A parser model built into the bench predicts each result beat.
// Both channel sides stall at random, and the result side holds off once
// for a long stretch.
// ---------------------------------------------------------------------------
module tb_http_response_head_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hrhp_pkg::*;

	typedef logic [7:0] octet_t;

	typedef struct {
		req_item_t beat;
		bit        typed;
		res_item_t want;
	} stim_row_t;

	localparam int unsigned RANDOM_BEATS = 1450;
	localparam int unsigned TAIL_BEATS   = 150;
	localparam int unsigned HOLD_AFTER   = 400;
	localparam int unsigned HOLD_CYCLES  = 150;

	logic clk;
	logic arst_n;

	hrhp_req_if request ();
	hrhp_res_if result ();

	http_response_head_parser_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	// parser model state
	logic [1:0]            hp_phase;
	logic [4:0]            hp_col;
	bit                    hp_prefix_good;
	bit                    hp_name_hit;
	bit                    hp_in_value;
	bit                    hp_num_done;
	bit                    hp_colon_pend;
	logic [9:0]            hp_code;
	logic [31:0]           hp_clen;
	logic [COUNT_BITS-1:0] hp_body_total;

	stim_row_t   stim_plan [$];
	res_item_t   pending_results [$];
	int unsigned mismatch_count;
	int unsigned results_seen;
	int unsigned connects_sent;
	int unsigned heads_closed;
	int unsigned body_beats;
	int unsigned error_events;
	bit          calm_tail;
	bit          hold_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d result beats outstanding", pending_results.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	function automatic void clear_parser();
		hp_phase       = PHASE_IDLE;
		hp_col         = '0;
		hp_prefix_good = 1'b1;
		hp_name_hit    = 1'b1;
		hp_in_value    = 1'b0;
		hp_num_done    = 1'b0;
		hp_colon_pend  = 1'b0;
		hp_code        = '0;
		hp_clen        = '0;
		hp_body_total  = '0;
	endfunction

	function automatic void start_line();
		hp_col        = '0;
		hp_name_hit   = 1'b1;
		hp_in_value   = 1'b0;
		hp_num_done   = 1'b0;
		hp_colon_pend = 1'b0;
	endfunction

	function automatic void advance_col();
		if (hp_col < POS_MAX) hp_col = hp_col + 5'd1;
	endfunction

	function automatic void status_char(octet_t c);
		int acc;
		if (hp_col < PREFIX_LEN) begin
			if (STATUS_PREFIX[hp_col] != CH_WILD && STATUS_PREFIX[hp_col] != c)
				hp_prefix_good = 1'b0;
		end else if (hp_prefix_good && !hp_num_done) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				acc = int'(hp_code) * 10 + int'(c - CH_ZERO);
				hp_code = (acc > int'(CODE_MAX)) ? CODE_MAX : acc[9:0];
			end else begin
				hp_num_done = 1'b1;
			end
		end
		advance_col();
	endfunction

	function automatic void name_char(octet_t c);
		octet_t lc;
		lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
		if (c == CH_COLON)
			hp_colon_pend = 1'b1;
		else if (hp_col >= NAME_LEN)
			hp_name_hit = 1'b0;
		else if (lc != LENGTH_NAME[hp_col])
			hp_name_hit = 1'b0;
		if (c == CH_COLON && hp_col >= NAME_LEN)
			hp_name_hit = hp_name_hit && (hp_col == NAME_LEN);
		advance_col();
	endfunction

	function automatic void header_char(octet_t c);
		longint unsigned v;
		if (hp_in_value) begin
			if (hp_name_hit && !hp_num_done) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					v = longint'(hp_clen) * 10 + longint'(c - CH_ZERO);
					hp_clen = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
				end else begin
					hp_num_done = 1'b1;
				end
			end
			advance_col();
			return;
		end
		if (hp_colon_pend) begin
			hp_colon_pend = 1'b0;
			if (c == CH_SPACE) begin
				// the ':' is counted, so a full name leaves the column one past it
				hp_name_hit = hp_name_hit && (hp_col == NAME_LEN + 5'd1);
				hp_in_value = 1'b1;
				hp_num_done = 1'b0;
				if (hp_name_hit) hp_clen = '0;
				advance_col();
				return;
			end
			hp_name_hit = 1'b0;
		end
		name_char(c);
	endfunction

	function automatic res_item_t predict_result(req_item_t b);
		res_item_t r;
		octet_t    c;
		r = '0;
		c = b.rx_byte;
		case (b.req_type)
			REQ_CONNECT: begin
				clear_parser();
				hp_phase = PHASE_STATUS;
			end
			REQ_DISCONNECT: hp_phase = PHASE_IDLE;
			REQ_TIMEOUT, REQ_CONN_ERROR: begin
				hp_phase      = PHASE_IDLE;
				r.error_valid = 1'b1;
				r.error_code  = (b.req_type == REQ_CONN_ERROR) ? ERR_CONN_FAIL : ERR_TIMEOUT;
			end
			REQ_DATA: begin
				case (hp_phase)
					PHASE_STATUS: begin
						if (c == CH_LF) begin
							if (hp_col < PREFIX_LEN) hp_prefix_good = 1'b0;
							hp_phase = PHASE_HEADER;
							start_line();
						end else if (c != CH_CR) begin
							status_char(c);
						end
					end
					PHASE_HEADER: begin
						if (c == CH_LF) begin
							if (hp_col == '0) begin
								hp_phase       = PHASE_BODY;
								r.headers_done = 1'b1;
							end else if (!hp_in_value && !hp_colon_pend && hp_name_hit
									&& hp_col == NAME_LEN) begin
								// bare name line clears the length
								hp_clen = '0;
							end
							start_line();
						end else if (c != CH_CR) begin
							header_char(c);
						end
					end
					PHASE_BODY: begin
						r.body_valid = 1'b1;
						r.body_byte  = c;
						if (hp_body_total != '1) hp_body_total = hp_body_total + 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.phase          = hp_phase;
		r.status_code    = hp_prefix_good ? hp_code : '0;
		r.content_length = hp_clen;
		r.body_count     = hp_body_total[31:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus plan
	// ------------------------------------------------------------------
	function automatic res_item_t mk_result(logic [1:0] ph, logic ev, logic ec);
		res_item_t r;
		r = '0;
		r.phase       = ph;
		r.error_valid = ev;
		r.error_code  = ec;
		return r;
	endfunction

	task automatic add_row(logic [2:0] req, octet_t data, bit typed, res_item_t want);
		stim_row_t row;
		row.beat.req_type = req;
		row.beat.rx_byte  = data;
		row.typed         = typed;
		row.want          = want;
		stim_plan.push_back(row);
	endtask

	task automatic add_data(octet_t c);
		add_row(REQ_DATA, c, 1'b0, '0);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_data(s[i]);
	endtask

	task automatic add_eol();
		if ($urandom_range(3) == 0) add_data(CH_CR);
		add_data(CH_LF);
	endtask

	function automatic octet_t rand_digit();
		return CH_ZERO + octet_t'($urandom_range(9));
	endfunction

	function automatic octet_t any_but_lf();
		octet_t c;
		do c = octet_t'($urandom_range(255)); while (c == CH_LF);
		return c;
	endfunction

	task automatic add_digits(int unsigned n);
		for (int i = 0; i < n; i++) add_data(rand_digit());
	endtask

	task automatic add_length_name(int unsigned n);
		octet_t c;
		for (int i = 0; i < n; i++) begin
			c = LENGTH_NAME[i];
			// flip letters to upper case at random; '-' sits below 'Z'
			if (c > CH_UP_Z && $urandom_range(1) == 1) c = c - CASE_GAP;
			add_data(c);
		end
	endtask

	task automatic add_status_line();
		int unsigned pick, bad;
		octet_t      c;
		pick = $urandom_range(99);
		if (pick < 70) begin
			add_text("HTTP/");
			add_data($urandom_range(3) == 0 ? any_but_lf() : rand_digit());
			add_text(".");
			add_data($urandom_range(3) == 0 ? any_but_lf() : rand_digit());
			add_text(" ");
			add_digits($urandom_range(0, 4));
			if ($urandom_range(1) == 1) add_text(" OK");
		end else if (pick < 80) begin
			// long codes, which may saturate
			add_text("HTTP/1.1 ");
			for (int i = 0; i < $urandom_range(4, 7); i++)
				add_data($urandom_range(1) == 1 ? CH_NINE : rand_digit());
		end else if (pick < 90) begin
			bad = $urandom_range(8);
			for (int i = 0; i < 9; i++) begin
				c = (STATUS_PREFIX[i] == CH_WILD) ? rand_digit() : STATUS_PREFIX[i];
				add_data(i == bad ? any_but_lf() : c);
			end
			add_digits($urandom_range(1, 3));
		end else begin
			// short status line
			for (int i = 0; i < $urandom_range(0, 8); i++)
				add_data(STATUS_PREFIX[i] == CH_WILD ? rand_digit() : STATUS_PREFIX[i]);
		end
		add_eol();
	endtask

	task automatic add_header_line();
		int unsigned pick;
		octet_t      c;
		pick = $urandom_range(99);
		if (pick < 30) begin
			add_length_name(14);
			add_text(": ");
			if ($urandom_range(99) < 15) add_digits($urandom_range(10, 12));
			else add_digits($urandom_range(0, 6));
			if ($urandom_range(99) < 30) begin
				add_data(any_but_lf());
				add_digits($urandom_range(0, 3));
			end
		end else if (pick < 40) begin
			add_length_name(14);
		end else if (pick < 48) begin
			// colon without space
			add_length_name(14);
			add_data(CH_COLON);
			do c = any_but_lf(); while (c == CH_SPACE);
			add_data(c);
			add_digits($urandom_range(1, 4));
		end else if (pick < 56) begin
			if ($urandom_range(1) == 1) begin
				add_length_name($urandom_range(10, 13));
			end else begin
				add_length_name(14);
				add_data(any_but_lf());
			end
			add_text(": ");
			add_digits($urandom_range(1, 5));
		end else if (pick < 80) begin
			for (int i = 0; i < $urandom_range(1, 20); i++)
				add_data(CH_UP_A + octet_t'($urandom_range(25)) + ($urandom_range(1) ? CASE_GAP : 8'd0));
			add_text(": ");
			for (int i = 0; i < $urandom_range(0, 15); i++) add_data(any_but_lf());
		end else begin
			for (int i = 0; i < $urandom_range(1, 40); i++) add_data(any_but_lf());
		end
		add_eol();
	endtask

	task automatic add_event();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45) add_row(REQ_DISCONNECT, octet_t'($urandom_range(255)), 1'b0, '0);
		else if (pick < 60) add_row(REQ_TIMEOUT, octet_t'($urandom_range(255)), 1'b0, '0);
		else if (pick < 75) add_row(REQ_CONN_ERROR, octet_t'($urandom_range(255)), 1'b0, '0);
		else add_row(3'(5 + $urandom_range(2)), octet_t'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic add_response();
		if ($urandom_range(99) < 90) add_row(REQ_CONNECT, octet_t'($urandom_range(255)), 1'b0, '0);
		add_status_line();
		for (int i = 0; i < $urandom_range(0, 5); i++) begin
			if ($urandom_range(99) < 4) begin
				// cut the head short
				add_event();
				return;
			end
			add_header_line();
		end
		add_eol();
		for (int i = 0; i < $urandom_range(0, 24); i++) add_data(octet_t'($urandom_range(255)));
		if ($urandom_range(99) < 65) add_event();
		if ($urandom_range(99) < 5)
			add_row(3'($urandom_range(7)), octet_t'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic build_plan();
		int unsigned directed_len;
		// after reset: idle data, unused codes and all events
		add_row(REQ_DATA, 8'hFF, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(3'd5, 8'h00, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(3'd6, 8'hAA, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(3'd7, 8'hFF, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(REQ_TIMEOUT, 8'h55, 1'b1, mk_result(PHASE_IDLE, 1'b1, ERR_TIMEOUT));
		add_row(REQ_CONN_ERROR, 8'h00, 1'b1, mk_result(PHASE_IDLE, 1'b1, ERR_CONN_FAIL));
		add_row(REQ_DISCONNECT, 8'hFF, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(REQ_CONNECT, 8'h00, 1'b1, mk_result(PHASE_STATUS, 1'b0, 1'b0));
		// short status line, colon without space, then a blank line
		add_text("HT\n");
		add_text("c:x\n");
		add_data(CH_CR);
		add_data(CH_LF);
		add_data(8'h00);
		add_data(8'hFF);
		// reconnect from the body clears everything
		add_row(REQ_CONNECT, 8'hFF, 1'b1, mk_result(PHASE_STATUS, 1'b0, 1'b0));
		add_row(REQ_DISCONNECT, 8'h00, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		add_row(REQ_DATA, 8'h80, 1'b1, mk_result(PHASE_IDLE, 1'b0, 1'b0));
		directed_len = stim_plan.size();
		while (stim_plan.size() < directed_len + RANDOM_BEATS) add_response();
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("Mismatch at result %0d: %s, got %0d expected %0d",
				results_seen, what, got, want);
	endtask

	task automatic check_result(res_item_t got, res_item_t want);
		if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
		if (got.status_code !== want.status_code)
			report_mismatch("status_code", got.status_code, want.status_code);
		if (got.content_length !== want.content_length)
			report_mismatch("content_length", got.content_length, want.content_length);
		if (got.headers_done !== want.headers_done)
			report_mismatch("headers_done", got.headers_done, want.headers_done);
		if (got.body_valid !== want.body_valid)
			report_mismatch("body_valid", got.body_valid, want.body_valid);
		if (got.body_byte !== want.body_byte)
			report_mismatch("body_byte", got.body_byte, want.body_byte);
		if (got.body_count !== want.body_count)
			report_mismatch("body_count", got.body_count, want.body_count);
		if (got.error_valid !== want.error_valid)
			report_mismatch("error_valid", got.error_valid, want.error_valid);
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", got.error_code, want.error_code);
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				check_result(result.item, want);
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: random stalls and one long hold-off
	// ------------------------------------------------------------------
	initial begin
		int unsigned gap_pct;
		gap_pct = 20;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				// hold off once, letting the block back up into the request side
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm_tail && $urandom_range(99) < gap_pct) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			if ($urandom_range(99) < 5) begin
				case ($urandom_range(2))
					0: gap_pct = 0;
					1: gap_pct = 20;
					default: gap_pct = 45;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	initial begin
		stim_row_t   row;
		res_item_t   predicted;
		int unsigned idle_pct;
		request.valid <= 1'b0;
		request.item  <= '0;
		mismatch_count = 0;
		results_seen   = 0;
		calm_tail      = 1'b0;
		hold_done      = 1'b0;
		idle_pct       = 15;
		clear_parser();
		build_plan();
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int unsigned idx = 0; idx < stim_plan.size(); idx++) begin
			row = stim_plan[idx];
			if (idx % 100 == 0) begin
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			if (idx + TAIL_BEATS >= stim_plan.size()) calm_tail = 1'b1;
			request.valid <= 1'b1;
			request.item  <= row.beat;
			do @(posedge clk); while (request.ready !== 1'b1);
			predicted = predict_result(row.beat);
			pending_results.push_back(row.typed ? row.want : predicted);
			if (row.beat.req_type == REQ_CONNECT) connects_sent++;
			if (predicted.headers_done) heads_closed++;
			if (predicted.body_valid) body_beats++;
			if (predicted.error_valid) error_events++;
			if (!calm_tail && $urandom_range(99) < idle_pct) begin
				request.valid <= 1'b0;
				request.item  <= req_item_t'($urandom_range(2047));
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
		request.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d request beats over %0d connects: %0d header sections closed,",
			stim_plan.size(), connects_sent, heads_closed);
		$display("%0d body bytes, %0d error events; %0d result beats checked, %0d mismatches",
			body_beats, error_events, results_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/hrhp_pkg.sv
src/hrhp_if.sv
src/hrhp_step.sv
src/http_response_head_parser_unit.sv
src/hrhp_checker.sv
tb/tb_http_response_head_parser_unit.sv
